// File: rtl/core/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared widths, function codes and record types for the encoder.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int SYM_W        = 8;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_ENCODE = 1'b1
  } func_t;

  // One code table entry; the code word is stored left-aligned.
  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } code_entry_t;

  // One encode item handed from the lookup stage to the packer.
  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic              last;
  } pk_item_t;

endpackage

// File: rtl/core/hcbp_in_if.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer input channel
// Valid/ready channel carrying load and encode items.
// ----------------------------------------------------------------------------
interface hcbp_in_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              last_symbol;

  modport source (output valid, func, symbol, code_bits, code_length, last_symbol,
                  input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, last_symbol,
                  output ready);
endinterface

// File: rtl/core/hcbp_out_if.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer output channel
// Valid/ready channel carrying packed bytes and end-of-stream status.
// ----------------------------------------------------------------------------
interface hcbp_out_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_stream;
  logic [CODE_W-1:0] stream_bits;
  logic              unknown_seen;

  modport source (output valid, out_byte, end_of_stream, stream_bits, unknown_seen,
                  input ready);
  modport sink   (input valid, out_byte, end_of_stream, stream_bits, unknown_seen,
                  output ready);
endinterface

// File: rtl/core/hcbp_code_mem.sv
// ----------------------------------------------------------------------------
// Huffman code table memory
// Synchronous code table with one write and one registered read port. A
// valid bit per entry makes unwritten entries read as having no code.
// ----------------------------------------------------------------------------
module hcbp_code_mem import hcbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  code_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output code_entry_t       rd_data
);

  code_entry_t             mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] filled;
  code_entry_t             rd_q;
  logic                    rd_filled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_filled <= filled[rd_addr];
      end
    end
  end

  assign rd_data.word = rd_q.word;
  assign rd_data.len  = rd_filled ? rd_q.len : '0;

endmodule

// File: rtl/core/hcbp_packer.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Appends code bits to an 8-bit accumulator, emits one byte per cycle into
// an output register while that register is free, and closes the stream with padding and status.
// ----------------------------------------------------------------------------
module hcbp_packer import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  pk_item_t   item,
  output logic       item_ready,
  hcbp_out_if.source stream
);

  logic              cur_valid;
  logic [CODE_W-1:0] cur_word;
  logic [LEN_W-1:0]  cur_rem;
  logic              cur_last;
  logic [BYTE_W-1:0] acc;
  logic [2:0]        pend;
  logic [CODE_W-1:0] total;
  logic              unknown;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_end;
  logic [CODE_W-1:0] out_bits;
  logic              out_unknown;

  logic [3:0]        need;
  logic              emit_br;
  logic [LEN_W-1:0]  rem2;
  logic [CODE_W-1:0] word2;
  logic [BYTE_W-1:0] byte_full;
  logic [2:0]        r;
  logic [BYTE_W-1:0] acc_abs;
  logic [2:0]        pend_abs;
  logic [BYTE_W-1:0] pad_byte;
  logic [BYTE_W-1:0] tail_acc;
  logic              out_free;

  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_end;
  logic              done;
  logic              take;
  logic [BYTE_W-1:0] acc_next;
  logic [2:0]        pend_next;
  logic [CODE_W-1:0] word_next;
  logic [LEN_W-1:0]  rem_next;
  logic [CODE_W-1:0] total_base;
  logic [CODE_W:0]   total_sum;
  logic [CODE_W-1:0] total_next;
  logic              unknown_next;

  // Bits still needed to complete the byte, and the two ways a step can go.
  always_comb begin
    need      = 4'(BYTE_W) - {1'b0, pend};
    emit_br   = cur_rem >= {2'b00, need};
    rem2      = cur_rem - {2'b00, need};
    word2     = cur_word << need;
    byte_full = (acc << need) | (cur_word[CODE_W-1 -: BYTE_W] >> pend);
    r         = cur_rem[2:0];
    acc_abs   = (acc << r) | (cur_word[CODE_W-1 -: BYTE_W] >> (4'(BYTE_W) - {1'b0, r}));
    pend_abs  = pend + r;
    pad_byte  = acc_abs << (4'(BYTE_W) - {1'b0, pend_abs});
    tail_acc  = word2[CODE_W-1 -: BYTE_W] >> (4'(BYTE_W) - {1'b0, rem2[2:0]});
    out_free  = !out_valid || stream.ready;
  end

  always_comb begin
    emit      = 1'b0;
    emit_byte = byte_full;
    emit_end  = 1'b0;
    done      = 1'b0;
    acc_next  = acc;
    pend_next = pend;
    word_next = cur_word;
    rem_next  = cur_rem;
    if (cur_valid) begin
      if (emit_br) begin
        if (out_free) begin
          emit = 1'b1;
          if (rem2 >= LEN_W'(BYTE_W)) begin
            word_next = word2;
            rem_next  = rem2;
            acc_next  = '0;
            pend_next = '0;
          end else if (!cur_last) begin
            acc_next  = tail_acc;
            pend_next = rem2[2:0];
            done      = 1'b1;
          end else if (rem2 == '0) begin
            // The stream ends on a byte boundary: this byte closes it.
            emit_end  = 1'b1;
            done      = 1'b1;
            acc_next  = '0;
            pend_next = '0;
          end else begin
            // Final item with a tail left: the pad byte follows once the output register is free.
            word_next = word2;
            rem_next  = rem2;
            acc_next  = '0;
            pend_next = '0;
          end
        end
      end else if (!cur_last) begin
        acc_next  = acc_abs;
        pend_next = pend_abs;
        done      = 1'b1;
      end else if (out_free) begin
        emit      = 1'b1;
        emit_byte = pad_byte;
        emit_end  = 1'b1;
        done      = 1'b1;
        acc_next  = '0;
        pend_next = '0;
      end
    end
  end

  assign item_ready = !cur_valid || done;
  assign take       = item_valid && item_ready;

  // Stream totals restart when the end byte is emitted into the output register; a new
  // item may join in that same cycle.
  always_comb begin
    total_base   = emit_end ? '0 : total;
    total_sum    = {1'b0, total_base} + (take ? (CODE_W+1)'(item.len) : '0);
    total_next   = total_sum[CODE_W] ? '1 : total_sum[CODE_W-1:0];
    unknown_next = (emit_end ? 1'b0 : unknown) | (take && (item.len == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      acc       <= '0;
      pend      <= '0;
      total     <= '0;
      unknown   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc     <= acc_next;
      pend    <= pend_next;
      total   <= total_next;
      unknown <= unknown_next;
      if (take) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_word <= item.word;
      cur_rem  <= item.len;
      cur_last <= item.last;
    end else begin
      cur_word <= word_next;
      cur_rem  <= rem_next;
    end
    if (emit) begin
      out_byte    <= emit_byte;
      out_end     <= emit_end;
      out_bits    <= emit_end ? total : '0;
      out_unknown <= emit_end && unknown;
    end
  end

  assign stream.valid         = out_valid;
  assign stream.out_byte      = out_byte;
  assign stream.end_of_stream = out_end;
  assign stream.stream_bits   = out_bits;
  assign stream.unknown_seen  = out_unknown;

endmodule

// File: rtl/core/huffman_code_bit_packer.sv
// The first byte of an encode item passes the lookup stage (the registered table read),
// the packer's current-item register and its output register. A load only writes the
// table. An encode item holds the packer until every byte it completes has been emitted
// (and a pad byte if a final item ends mid-byte); the next item enters as it finishes.
// Reset (synchronous, active high) empties the pipeline, zeroes the packer and marks
// every code table entry as having no code in the same cycle; no clearing pass.
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Static Huffman encoder: code table loads, table lookup and byte packing.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hcbp_in_if.sink    items,
  hcbp_out_if.source stream
);

  logic              accept;
  logic              is_enc;
  logic              sym_ok;
  logic [LEN_W-1:0]  len_c;
  logic              wr_en;
  logic              rd_en;
  code_entry_t       wr_data;
  code_entry_t       rd_data;
  logic              s1_valid;
  logic              s1_last;
  logic              s1_sym_ok;
  logic              pk_ready;
  pk_item_t          pk_item;

  assign accept = items.valid && items.ready;
  assign is_enc = items.func == FUNC_ENCODE;
  assign sym_ok = {1'b0, items.symbol} < (SYM_W+1)'(SYMBOL_COUNT);
  assign len_c  = (items.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                          : items.code_length;

  // Codes are stored left-aligned so the packer always takes bits from the top.
  assign wr_data.word = items.code_bits << (LEN_W'(CODE_W) - len_c);
  assign wr_data.len  = len_c;
  assign wr_en        = accept && !is_enc && sym_ok;
  assign rd_en        = accept && is_enc;

  hcbp_code_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (items.symbol[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (items.symbol[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign items.ready = !s1_valid || pk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (pk_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_last   <= items.last_symbol;
      s1_sym_ok <= sym_ok;
    end
  end

  assign pk_item.word = rd_data.word;
  assign pk_item.len  = s1_sym_ok ? rd_data.len : '0;
  assign pk_item.last = s1_last;

  hcbp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .item       (pk_item),
    .item_ready (pk_ready),
    .stream     (stream)
  );

  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> s1_valid)
    else $error("Encode transaction did not reach the lookup stage.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> s1_valid && !pk_ready)
    else $error("Input stalled without a waiting lookup.");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    stream.valid && !stream.end_of_stream |->
      stream.stream_bits == '0 && !stream.unknown_seen)
    else $error("Stream status shown on a byte that does not end the stream.");

endmodule

// File: tb/sv/huffman_code_bit_packer_tb.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Loads code table entries and encodes symbol streams through the valid/ready
// channels. A local model of the table and the byte packer predicts every
// packed byte, and each output transaction is checked field by field in order.
// The sender runs in random bursts and the receiver stalls on its own pattern,
// with one long hold-off that backs the pipeline up into the input channel.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 100;
  localparam int HOLD_TRIGGER   = 12;
  localparam int RANDOM_ITEMS   = 96;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct {
    func_t             func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_symbol;
  } symbol_item_t;

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_stream;
    logic [CODE_W-1:0] stream_bits;
    logic              unknown_seen;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst;

  hcbp_in_if  items_ch ();
  hcbp_out_if stream_ch ();

  huffman_code_bit_packer uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .stream (stream_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the code table and the packer state.
  logic [CODE_W-1:0] code_words   [SYMBOL_COUNT];
  logic [LEN_W-1:0]  code_lengths [SYMBOL_COUNT];
  logic [BYTE_W-1:0] acc_byte;
  int                acc_count;
  logic [CODE_W-1:0] bit_total;
  logic              missing_code;

  symbol_item_t pending_items  [$];
  packed_byte_t expected_bytes [$];
  symbol_item_t cur_item;

  int errors;
  int load_count;
  int encode_count;
  int stream_count;
  int bytes_checked;
  int ends_checked;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int unsigned rx_cycle;
  int idle_cycles;

  task automatic queue_load(input int sym, input logic [CODE_W-1:0] bits, input int len,
                            input bit last);
    symbol_item_t it;
    it.func        = FUNC_LOAD;
    it.symbol      = SYM_W'(sym);
    it.code_bits   = bits;
    it.code_length = LEN_W'(len);
    it.last_symbol = last;
    pending_items.push_back(it);
  endtask

  task automatic queue_encode(input int sym, input bit last);
    symbol_item_t it;
    it.func        = FUNC_ENCODE;
    it.symbol      = SYM_W'(sym);
    it.code_bits   = $urandom;
    it.code_length = LEN_W'($urandom_range(0, 63));
    it.last_symbol = last;
    pending_items.push_back(it);
  endtask

  // Applies one accepted transaction to the table and packer and queues the
  // bytes it produces.
  task automatic pack_symbol(input symbol_item_t it);
    int unsigned       len;
    logic [32:0]       sum;
    logic [BYTE_W-1:0] padded;
    packed_byte_t      rec;
    packed_byte_t      batch [$];
    int                last_idx;
    if (it.func == FUNC_LOAD) begin
      load_count++;
      if (int'(it.symbol) < SYMBOL_COUNT) begin
        code_lengths[it.symbol] = (it.code_length > LEN_LIMIT) ? LEN_W'(LEN_LIMIT)
                                                               : it.code_length;
        code_words[it.symbol] = it.code_bits;
      end
    end else begin
      encode_count++;
      len = 0;
      if (int'(it.symbol) < SYMBOL_COUNT) len = code_lengths[it.symbol];
      if (len == 0) missing_code = 1'b1;
      for (int i = len; i > 0; i--) begin
        acc_byte = {acc_byte[BYTE_W-2:0], code_words[it.symbol][i-1]};
        acc_count++;
        if (acc_count == BYTE_W) begin
          rec = '{out_byte: acc_byte, end_of_stream: 1'b0, stream_bits: '0,
                  unknown_seen: 1'b0};
          batch.push_back(rec);
          acc_byte  = '0;
          acc_count = 0;
        end
      end
      sum = {1'b0, bit_total} + len;
      bit_total = sum[32] ? '1 : sum[31:0];
      if (it.last_symbol) begin
        // A partial byte is zero-padded; an empty tail still gets an end marker.
        if (acc_count > 0) begin
          padded = acc_byte << (BYTE_W - acc_count);
          rec = '{out_byte: padded, end_of_stream: 1'b0, stream_bits: '0,
                  unknown_seen: 1'b0};
          batch.push_back(rec);
        end else if (batch.size() == 0) begin
          rec = '{out_byte: '0, end_of_stream: 1'b0, stream_bits: '0, unknown_seen: 1'b0};
          batch.push_back(rec);
        end
        last_idx = batch.size() - 1;
        batch[last_idx].end_of_stream = 1'b1;
        batch[last_idx].stream_bits   = bit_total;
        batch[last_idx].unknown_seen  = missing_code;
        acc_byte     = '0;
        acc_count    = 0;
        bit_total    = '0;
        missing_code = 1'b0;
        stream_count++;
      end
      foreach (batch[k]) expected_bytes.push_back(batch[k]);
    end
  endtask

  // Sender: offers queued items in bursts with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      if (items_ch.valid && items_ch.ready) pack_symbol(cur_item);
      if (!items_ch.valid || items_ch.ready) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          items_ch.valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          items_ch.valid       <= 1'b1;
          items_ch.func        <= cur_item.func;
          items_ch.symbol      <= cur_item.symbol;
          items_ch.code_bits   <= cur_item.code_bits;
          items_ch.code_length <= cur_item.code_length;
          items_ch.last_symbol <= cur_item.last_symbol;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (rst) begin
      stream_ch.ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (stream_ch.valid && stream_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output: byte %h eos %b bits %0d unknown %b", $time,
                   stream_ch.out_byte, stream_ch.end_of_stream, stream_ch.stream_bits,
                   stream_ch.unknown_seen);
          errors++;
        end else begin
          if (stream_ch.out_byte !== expected_bytes[0].out_byte ||
              stream_ch.end_of_stream !== expected_bytes[0].end_of_stream ||
              stream_ch.stream_bits !== expected_bytes[0].stream_bits ||
              stream_ch.unknown_seen !== expected_bytes[0].unknown_seen) begin
            $display("%0t: mismatch: expected byte %h eos %b bits %0d unknown %b", $time,
                     expected_bytes[0].out_byte, expected_bytes[0].end_of_stream,
                     expected_bytes[0].stream_bits, expected_bytes[0].unknown_seen);
            $display("%0t:           actual   byte %h eos %b bits %0d unknown %b", $time,
                     stream_ch.out_byte, stream_ch.end_of_stream, stream_ch.stream_bits,
                     stream_ch.unknown_seen);
            errors++;
          end
          if (expected_bytes[0].end_of_stream) ends_checked++;
          void'(expected_bytes.pop_front());
          bytes_checked++;
        end
      end
      rx_cycle++;
      // One long hold-off so the packer backs up into the input channel.
      if (!hold_done && bytes_checked >= HOLD_TRIGGER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stream_ch.ready <= 1'b0;
      end else begin
        case (rx_cycle[7:6])
          2'd0: stream_ch.ready <= 1'b1;
          2'd1: stream_ch.ready <= ($urandom_range(0, 1) == 1);
          2'd2: stream_ch.ready <= ((rx_cycle % 5) != 0);
          default: stream_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((items_ch.valid && items_ch.ready) || (stream_ch.valid && stream_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d items unsent, %0d bytes outstanding",
               $time, idle_cycles, pending_items.size(), expected_bytes.size());
      $display("** huffman_code_bit_packer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int loaded_syms [$];
    int sym;
    int len;
    int pick;

    rst = 1'b1;
    items_ch.valid       = 1'b0;
    items_ch.func        = FUNC_LOAD;
    items_ch.symbol      = '0;
    items_ch.code_bits   = '0;
    items_ch.code_length = '0;
    items_ch.last_symbol = 1'b0;
    stream_ch.ready      = 1'b0;
    foreach (code_words[k]) begin
      code_words[k]   = '0;
      code_lengths[k] = '0;
    end
    acc_byte      = '0;
    acc_count     = 0;
    bit_total     = '0;
    missing_code  = 1'b0;
    errors        = 0;
    load_count    = 0;
    encode_count  = 0;
    stream_count  = 0;
    bytes_checked = 0;
    ends_checked  = 0;

    // Directed part. An empty stream ending on a symbol without a code comes first.
    queue_encode(8'h3C, 1'b1);
    queue_load(8'h00, 32'h0000_00A5, 8, 1'b0);
    queue_load(8'hFF, 32'hFFFF_FFFF, 32, 1'b0);
    queue_load(8'h01, 32'h1234_5678, 63, 1'b1);
    queue_load(8'h02, 32'hFFFF_FFFF, 1, 1'b0);
    queue_load(8'h03, 32'hDEAD_BEEF, 0, 1'b0);
    queue_load(8'h04, 32'h0000_002A, 7, 1'b0);
    queue_load(8'h80, 32'h0000_0000, 3, 1'b0);
    queue_load(8'h05, 32'h0000_0000, 32, 1'b0);
    queue_encode(8'h00, 1'b1);
    queue_encode(8'h02, 1'b1);
    queue_encode(8'hFF, 1'b0);
    queue_encode(8'h01, 1'b1);
    queue_encode(8'h03, 1'b0);
    queue_encode(8'h02, 1'b1);
    queue_encode(8'h00, 1'b0);
    queue_encode(8'h03, 1'b1);
    queue_encode(8'h04, 1'b0);
    queue_encode(8'hFF, 1'b1);
    queue_encode(8'h80, 1'b0);
    queue_encode(8'h05, 1'b0);
    queue_encode(8'h04, 1'b1);
    queue_load(8'h00, 32'h0F0F_0F0F, 40, 1'b0);
    queue_encode(8'h00, 1'b1);
    loaded_syms = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h80, 8'h05};

    // Random part: mostly encodes of loaded symbols, with table rewrites mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        sym  = $urandom_range(0, 255);
        pick = $urandom_range(0, 9);
        if (pick < 7) len = $urandom_range(1, 12);
        else if (pick < 9) len = $urandom_range(13, 32);
        else len = $urandom_range(33, 63);
        if ($urandom_range(0, 19) == 0) len = 0;
        queue_load(sym, $urandom, len, $urandom_range(0, 1));
        loaded_syms.push_back(sym);
      end else begin
        if ($urandom_range(0, 6) == 0) sym = $urandom_range(0, 255);
        else sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        queue_encode(sym, $urandom_range(0, 5) == 0);
      end
    end
    queue_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)], 1'b1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || items_ch.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d table loads and %0d encoded symbols in %0d streams.",
             load_count, encode_count, stream_count);
    $display("Checked %0d packed bytes, %0d of them stream ends, with a %0d-cycle hold-off.",
             bytes_checked, ends_checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("** huffman_code_bit_packer: PASSED **");
    end else begin
      $display("** huffman_code_bit_packer: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_in_if.sv
rtl/core/hcbp_out_if.sv
rtl/core/hcbp_code_mem.sv
rtl/core/hcbp_packer.sv
rtl/core/huffman_code_bit_packer.sv
tb/sv/huffman_code_bit_packer_tb.sv
